FILE: sv/bfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and codes for the bus frame receiver: status and reply codes,
// configuration register indexes, and the configuration and result records.
// ----------------------------------------------------------------------------
package bfr_pkg;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_NOT_ADDR = 3'd3,
    ST_FAIL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RP_NONE = 2'd0,
    RP_ACK  = 2'd1,
    RP_NAK  = 2'd2
  } reply_t;

  typedef enum logic [2:0] {
    CFG_OWN_DEVICE_ID  = 3'd0,
    CFG_OWN_BUS_ID     = 3'd1,
    CFG_SHARED_NETWORK = 3'd2,
    CFG_ROUTER_MODE    = 3'd3,
    CFG_SIMPLEX_MODE   = 3'd4
  } cfg_idx_t;

  localparam logic [7:0] CRC_POLY      = 8'h8C;
  localparam logic [7:0] MIN_LENGTH    = 8'd4;
  localparam logic [7:0] BROADCAST_ID  = 8'd0;
  localparam logic [7:0] UNASSIGNED_ID = 8'd255;
  localparam logic [3:0] HDR_BYTES     = 4'd3;
  localparam logic [3:0] BUS_ID_BYTES  = 4'd4;
  localparam logic [3:0] SHARED_SENDER_SKIP = 4'd9;
  localparam logic [7:0] IDX_RECIPIENT = 8'd0;
  localparam logic [7:0] IDX_LENGTH    = 8'd1;
  localparam logic [7:0] IDX_HEADER    = 8'd2;
  localparam logic [7:0] IDX_BUS_FIRST = 8'd3;
  localparam logic [7:0] IDX_BUS_LAST  = 8'd6;
  localparam logic [7:0] IDX_SENDER_LOCAL  = 8'd3;
  localparam logic [7:0] IDX_SENDER_SHARED = 8'd11;

  typedef struct packed {
    logic [7:0]  own_device_id;
    logic [31:0] own_bus_id;
    logic        shared_network;
    logic        router_mode;
    logic        simplex_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic       frame_end;
    status_t    status;
    reply_t     reply;
    logic [3:0] data_start;
    logic [7:0] payload_length;
    logic [7:0] source_id;
    logic [7:0] header_bits;
  } res_t;

endpackage

FILE: sv/bus_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_frame_receiver
// Addressed serial frame receiver with reflected CRC-8 check.
//
// Input channel (in_valid / in_stall) carries one received bus byte per
// request, with in_rx_fail marking a failed reception. Every request yields
// exactly one result request on the out_ channel: the byte, its position in
// the frame, and at the last byte of a frame the final status, the ack or
// nak reply, the payload offset and length and the sender id.
// The result appears in the cycle after its input request is accepted. One
// byte is taken per cycle while in_stall is low; the frame decode and the CRC
// byte step sit between the input port and the result register.
// A stalled result holds in the result register; in_stall rises only while
// that register is full and out_stall is high.
// Configuration is written via cfg_we / cfg_index / cfg_wdata, one register
// per cycle, by the user only while no request is in flight (not enforced).
// Reset (rst_n low, synchronous) empties the result register, restores the
// register defaults (device id 255) and starts a new frame.
// ----------------------------------------------------------------------------
module bus_frame_receiver #(
  parameter int MAX_FRAME_LENGTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_fail,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_value,
  output logic [7:0]  out_byte_index,
  output logic        out_frame_end,
  output logic [2:0]  out_status,
  output logic [1:0]  out_reply,
  output logic [3:0]  out_data_start,
  output logic [7:0]  out_payload_length,
  output logic [7:0]  out_source_id,
  output logic [7:0]  out_header_bits
);

  bfr_pkg::cfg_t cfg_r;
  bfr_pkg::res_t res;
  bfr_pkg::res_t res_r;
  logic          out_valid_r, out_valid_nxt;
  logic          in_accept;

  assign in_stall      = out_valid_r && out_stall;
  assign in_accept     = in_valid && !in_stall;
  assign out_valid_nxt = in_accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_device_id  <= bfr_pkg::UNASSIGNED_ID;
      cfg_r.own_bus_id     <= '0;
      cfg_r.shared_network <= 1'b0;
      cfg_r.router_mode    <= 1'b0;
      cfg_r.simplex_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bfr_pkg::CFG_OWN_DEVICE_ID:  cfg_r.own_device_id  <= cfg_wdata[7:0];
        bfr_pkg::CFG_OWN_BUS_ID:     cfg_r.own_bus_id     <= cfg_wdata;
        bfr_pkg::CFG_SHARED_NETWORK: cfg_r.shared_network <= cfg_wdata[0];
        bfr_pkg::CFG_ROUTER_MODE:    cfg_r.router_mode    <= cfg_wdata[0];
        bfr_pkg::CFG_SIMPLEX_MODE:   cfg_r.simplex_mode   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  bfr_frame_ctl #(
    .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
  ) u_ctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_accept),
    .rx_byte (in_rx_byte),
    .rx_fail (in_rx_fail),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_value     = res_r.byte_value;
  assign out_byte_index     = res_r.byte_index;
  assign out_frame_end      = res_r.frame_end;
  assign out_status         = res_r.status;
  assign out_reply          = res_r.reply;
  assign out_data_start     = res_r.data_start;
  assign out_payload_length = res_r.payload_length;
  assign out_source_id      = res_r.source_id;
  assign out_header_bits    = res_r.header_bits;

endmodule

FILE: sv/bfr_crc8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_crc8
// One byte step of the reflected CRC-8, polynomial 0x8C, LSB first.
// ----------------------------------------------------------------------------
module bfr_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ data_in[k];
      c  = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ bfr_pkg::CRC_POLY;
      end
    end
    crc_out = c;
  end

endmodule

FILE: sv/bfr_frame_ctl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_frame_ctl
// Per-frame state and byte decode: address, length, header and bus id checks,
// CRC update, sender capture and the result of each accepted byte.
// ----------------------------------------------------------------------------
module bfr_frame_ctl #(
  parameter int MAX_FRAME_LENGTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic [7:0]    rx_byte,
  input  logic          rx_fail,
  input  bfr_pkg::cfg_t cfg,
  output bfr_pkg::res_t res
);

  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       shared_r, shared_nxt;
  logic       sinfo_r, sinfo_nxt;
  logic       ackreq_r, ackreq_nxt;
  logic [7:0] recip_r, recip_nxt;
  logic       match_r, match_nxt;
  logic [7:0] sender_r, sender_nxt;
  logic [7:0] hdr_r, hdr_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [7:0] crc_step;

  bfr_crc8 u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_step)
  );

  always_comb begin
    logic       ended;
    logic       clr;
    logic [1:0] sel;
    logic [7:0] sender_pos;
    logic [8:0] cnt_inc;
    logic       ok;
    logic       may_reply;
    logic [3:0] off;
    logic [8:0] off_len;
    ended      = 1'b0;
    clr        = 1'b0;
    sel        = 2'(3'd6 - cnt_r[2:0]);
    sender_pos = shared_r ? bfr_pkg::IDX_SENDER_SHARED : bfr_pkg::IDX_SENDER_LOCAL;
    cnt_inc    = {1'b0, cnt_r} + 9'd1;
    ok         = 1'b0;
    may_reply  = 1'b0;
    off        = '0;
    off_len    = '0;

    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    shared_nxt = shared_r;
    sinfo_nxt  = sinfo_r;
    ackreq_nxt = ackreq_r;
    recip_nxt  = recip_r;
    match_nxt  = match_r;
    sender_nxt = sender_r;
    hdr_nxt    = hdr_r;
    pend_nxt   = pend_r;

    res                = '0;
    res.status         = bfr_pkg::ST_BUSY;
    res.reply          = bfr_pkg::RP_NONE;
    res.byte_index     = cnt_r;

    if (rx_fail) begin
      ended      = 1'b1;
      clr        = 1'b1;
      res.status = bfr_pkg::ST_FAIL;
    end else begin
      res.byte_value = rx_byte;
      if (cnt_r == bfr_pkg::IDX_RECIPIENT) begin
        recip_nxt = rx_byte;
        if (rx_byte != cfg.own_device_id && rx_byte != bfr_pkg::BROADCAST_ID &&
            !cfg.router_mode) begin
          ended      = 1'b1;
          clr        = 1'b1;
          res.status = bfr_pkg::ST_NOT_ADDR;
        end
      end else if (cnt_r == bfr_pkg::IDX_LENGTH) begin
        if (rx_byte > bfr_pkg::MIN_LENGTH && int'(rx_byte) < MAX_FRAME_LENGTH) begin
          len_nxt = rx_byte;
        end else begin
          ended      = 1'b1;
          clr        = 1'b1;
          res.status = bfr_pkg::ST_FAIL;
        end
      end else if (cnt_r == bfr_pkg::IDX_HEADER) begin
        hdr_nxt    = rx_byte;
        shared_nxt = rx_byte[0];
        sinfo_nxt  = rx_byte[1];
        ackreq_nxt = rx_byte[2];
        if (rx_byte[0] != cfg.shared_network && !cfg.router_mode) begin
          ended           = 1'b1;
          clr             = 1'b1;
          res.status      = bfr_pkg::ST_NOT_ADDR;
          res.header_bits = rx_byte;
        end
      end else if (cnt_r inside {[bfr_pkg::IDX_BUS_FIRST:bfr_pkg::IDX_BUS_LAST]}) begin
        if (rx_byte != cfg.own_bus_id[8*sel +: 8]) begin
          match_nxt = 1'b0;
          if (cfg.shared_network && shared_r && !cfg.router_mode) begin
            ended           = 1'b1;
            clr             = 1'b1;
            res.status      = bfr_pkg::ST_NOT_ADDR;
            res.header_bits = hdr_r;
          end
        end
      end

      if (!ended) begin
        if (cnt_r >= bfr_pkg::IDX_HEADER) begin
          res.header_bits = hdr_nxt;
        end
        if (sinfo_nxt && cnt_r == sender_pos) begin
          pend_nxt = rx_byte;
        end
        crc_nxt = crc_step;
        cnt_nxt = cnt_inc[7:0];
        if (cnt_r >= bfr_pkg::IDX_HEADER && cnt_inc >= {1'b0, len_r}) begin
          clr       = 1'b1;
          ok        = (crc_step == 8'd0);
          may_reply = ackreq_r && recip_r != bfr_pkg::BROADCAST_ID &&
                      !cfg.simplex_mode &&
                      (!cfg.shared_network || (shared_r && match_nxt));
          res.frame_end = 1'b1;
          res.status    = ok ? bfr_pkg::ST_OK : bfr_pkg::ST_CRC_ERR;
          if (may_reply) begin
            res.reply = ok ? bfr_pkg::RP_ACK : bfr_pkg::RP_NAK;
          end
          if (ok) begin
            off = bfr_pkg::HDR_BYTES +
                  (shared_r ? (sinfo_r ? bfr_pkg::SHARED_SENDER_SKIP : bfr_pkg::BUS_ID_BYTES)
                            : (sinfo_r ? 4'd1 : 4'd0));
            off_len = {1'b0, len_r} - {5'd0, off} - 9'd1;
            if (sinfo_r) begin
              sender_nxt = pend_nxt;
            end
            res.data_start     = off;
            res.payload_length = off_len[8] ? 8'd0 : off_len[7:0];
            res.source_id      = sinfo_r ? pend_nxt : sender_r;
          end
        end
      end
    end

    if (ended) begin
      res.frame_end = 1'b1;
    end
    if (clr) begin
      cnt_nxt    = '0;
      len_nxt    = '0;
      crc_nxt    = '0;
      shared_nxt = 1'b0;
      sinfo_nxt  = 1'b0;
      ackreq_nxt = 1'b0;
      recip_nxt  = '0;
      match_nxt  = 1'b1;
      hdr_nxt    = '0;
      pend_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      len_r    <= '0;
      crc_r    <= '0;
      shared_r <= 1'b0;
      sinfo_r  <= 1'b0;
      ackreq_r <= 1'b0;
      recip_r  <= '0;
      match_r  <= 1'b1;
      sender_r <= '0;
      hdr_r    <= '0;
      pend_r   <= '0;
    end else if (advance) begin
      cnt_r    <= cnt_nxt;
      len_r    <= len_nxt;
      crc_r    <= crc_nxt;
      shared_r <= shared_nxt;
      sinfo_r  <= sinfo_nxt;
      ackreq_r <= ackreq_nxt;
      recip_r  <= recip_nxt;
      match_r  <= match_nxt;
      sender_r <= sender_nxt;
      hdr_r    <= hdr_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule
